// ===== rtl/core/vwh_pkg.sv =====
// Package for the vertex weld hash table: payload structs, sizes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package vwh_pkg;
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned EpochW = 8;
  localparam logic [31:0] GridScaleRst = 32'd65536000;

  typedef struct packed {
    logic start_mesh;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] weld_x;
    logic signed [31:0] weld_y;
    logic signed [31:0] weld_z;
    logic was_merged;
    logic table_full;
    logic [12:0] unique_total;
    logic [31:0] merged_total;
  } out_word_t;

  // slot entry: epoch tag marks validity for the current mesh
  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);
endpackage

// ===== rtl/core/vwh_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vwh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/vwh_key.sv =====
// Cell key unit: one coordinate times grid scale, rounded, with the product registered.
// Depends on vwh_pkg.
`timescale 1ns / 1ps
module vwh_key (
  input  logic        clk_i,
  input  logic [31:0] pos_i,
  input  logic [31:0] scale_i,
  output logic [31:0] key_o
);
  import vwh_pkg::*;
  logic        neg_q;
  logic [63:0] prod_q;
  logic [31:0] mag;
  logic [32:0] q;
  always_comb mag = pos_i[31] ? (~pos_i + 32'd1) : pos_i;
  always_ff @(posedge clk_i) begin
    neg_q  <= pos_i[31];
    prod_q <= {32'd0, mag} * {32'd0, scale_i};
  end
  always_comb begin
    q = 33'((prod_q + 64'h8000_0000) >> 32);
    if (!neg_q) key_o = (q > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    else key_o = 32'd0 - q[31:0];
  end
endmodule

// ===== rtl/core/vertex_weld_hash_table_core.sv =====
// Top level of the vertex weld hash table: key units, probe sequencer, slot RAM.
// Depends on vwh_pkg, vwh_key, vwh_ram.
`timescale 1ns / 1ps
// One word in, one word out. A result is presented after its word is
// accepted, passing through the key multiply (product registered in the key
// units), one read of the slot RAM (registered read data), one compare and
// the result state. Each extra probe step repeats the read and the compare.
// The next word is accepted only after the result has left. Valid slots are
// marked by an 8-bit mesh epoch stored with each entry; every 255 meshes, and
// after reset, a clearing pass rewrites all TableDepth (4096) entries while no
// word is accepted, and the word that wrapped the epoch waits for it. Probing
// stops at a match, at a slot of an older epoch, or after TableDepth slots
// (table full).
module vertex_weld_hash_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vwh_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vwh_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);
  import vwh_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_KEY = 6'b000100,
    S_READ = 6'b001000, S_CMP = 6'b010000, S_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] scale_q;
  in_word_t in_q;
  logic [31:0] kx, ky, kz;
  logic [31:0] kx_q, ky_q, kz_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0] n_q, n_d;
  logic [EpochW-1:0] epoch_q, epoch_d;
  logic [31:0] uniq_q, uniq_d, merge_q, merge_d;
  logic key_wait_q;
  out_word_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic hit, empty;
  logic [31:0] h;

  vwh_key u_kx (.clk_i, .pos_i(in_q.pos_x), .scale_i(scale_q), .key_o(kx));
  vwh_key u_ky (.clk_i, .pos_i(in_q.pos_y), .scale_i(scale_q), .key_o(ky));
  vwh_key u_kz (.clk_i, .pos_i(in_q.pos_z), .scale_i(scale_q), .key_o(kz));

  vwh_ram #(.Width(SlotW), .Depth(TableDepth)) u_slots (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  // home slot from the keys as they leave the key units
  assign h = kx ^ (ky << 1) ^ (kz << 2);
  assign raddr = idx_q;
  assign empty = rdata.epoch != epoch_q;
  assign hit = !empty && rdata.kx == kx_q && rdata.ky == ky_q && rdata.kz == kz_q;

  always_comb begin
    state_d = state_q; idx_d = idx_q; n_d = n_q; epoch_d = epoch_q;
    uniq_d = uniq_q; merge_d = merge_q; out_d = out_q; out_valid_d = out_valid_q;
    we = 1'b0; waddr = idx_q;
    wdata = '{epoch: epoch_q, kx: kx_q, ky: ky_q, kz: kz_q,
              px: in_q.pos_x, py: in_q.pos_y, pz: in_q.pos_z};
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // sweep: tag every entry with epoch 0, live epoch starts at 1
        we = 1'b1; wdata.epoch = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(TableDepth - 1)) begin
          epoch_d = EpochW'(1);
          // resume the word that wrapped the epoch, after reset go idle
          state_d = (epoch_q == '1) ? S_KEY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          state_d = S_KEY;
          if (in_data_i.start_mesh) begin
            uniq_d = '0; merge_d = '0;
            if (epoch_q == '1) begin
              state_d = S_CLEAR; idx_d = '0;
            end else epoch_d = epoch_q + 1'b1;
          end
        end
      end
      S_KEY: begin
        if (!key_wait_q) begin
          idx_d = h[IdxW-1:0]; n_d = '0; state_d = S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        out_d.weld_x = in_q.pos_x; out_d.weld_y = in_q.pos_y;
        out_d.weld_z = in_q.pos_z;
        out_d.was_merged = 1'b0; out_d.table_full = 1'b0;
        if (empty) begin
          we = 1'b1; uniq_d = uniq_q + 32'd1; state_d = S_OUT;
        end else if (hit) begin
          out_d.weld_x = rdata.px; out_d.weld_y = rdata.py; out_d.weld_z = rdata.pz;
          out_d.was_merged = 1'b1;
          if (merge_q != '1) merge_d = merge_q + 32'd1;
          state_d = S_OUT;
        end else if (n_q == (IdxW+1)'(TableDepth - 1)) begin
          out_d.table_full = 1'b1; state_d = S_OUT;
        end else begin
          idx_d = idx_q + 1'b1; n_d = n_q + 1'b1; state_d = S_READ;
        end
      end
      S_OUT: begin
        out_d.unique_total = uniq_q[12:0]; out_d.merged_total = merge_q;
        out_valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; idx_q <= '0; n_q <= '0; epoch_q <= '0;
      uniq_q <= '0; merge_q <= '0; out_valid_q <= 1'b0;
      scale_q <= GridScaleRst; key_wait_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; n_q <= n_d; epoch_q <= epoch_d;
      uniq_q <= uniq_d; merge_q <= merge_d; out_valid_q <= out_valid_d;
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      // wait flag so the product is registered before keys are taken
      key_wait_q <= (state_q != S_KEY) && (state_d == S_KEY);
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (state_q == S_KEY && !key_wait_q) begin
      kx_q <= kx; ky_q <= ky; kz_q <= kz;
    end
  end

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> out_valid_q) else $error("result not raised");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("accept while result pending");
  a_clear_no_write_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> we) else $error("clear pass stalled");
endmodule
